@@ rtl/obb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants and types for the oriented-box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int QUAT_W       = 16;
    localparam int HALF_FIELD_W = 20;
    localparam int POS_FIELD_W  = 24;
    localparam int FIFO_DEPTH   = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic valid;
        logic op;
    } t_stage_ctl;

endpackage

@@ rtl/obb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_front
// Accepts items, forms the quaternion products and turns them into axes.
// ----------------------------------------------------------------------------
module obb_front #(
    parameter int POS_WIDTH     = 24,
    parameter int EXTENT_WIDTH  = 20,
    parameter int ROT_FRAC_BITS = 14
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic                                        i_op,
    input  logic signed [obb_pkg::QUAT_W-1:0]           i_qw,
    input  logic signed [obb_pkg::QUAT_W-1:0]           i_qx,
    input  logic signed [obb_pkg::QUAT_W-1:0]           i_qy,
    input  logic signed [obb_pkg::QUAT_W-1:0]           i_qz,
    input  logic [3*EXTENT_WIDTH-1:0]                   i_half,
    input  logic [3*POS_WIDTH-1:0]                      i_pos,
    input  logic                                        i_full,
    output logic                                        o_push,
    output logic [1+9*(ROT_FRAC_BITS+2)+3*EXTENT_WIDTH+3*POS_WIDTH-1:0] o_data
);

    localparam int F  = ROT_FRAC_BITS;
    localparam int AW = F + 2;
    localparam int PW = 2 * obb_pkg::QUAT_W;
    localparam int SW = (2 * F + 4 > PW + 4) ? 2 * F + 4 : PW + 4;
    localparam logic signed [SW-1:0] ONE  = SW'(1) <<< (2 * F);
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
    localparam logic signed [SW-1:0] AMAX = (SW'(1) <<< (AW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] AMIN = -AMAX - SW'(1);

    function automatic logic signed [AW-1:0] axis_fix(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + HALF) >>> F;
        if (r > AMAX) begin
            r = AMAX;
        end else if (r < AMIN) begin
            r = AMIN;
        end
        return r[AW-1:0];
    endfunction

    logic                       en;
    obb_pkg::t_stage_ctl        r_f1, r_f2;
    logic signed [PW-1:0]       r_p [9];
    logic [3*EXTENT_WIDTH-1:0]  r_f1_half, r_f2_half;
    logic [3*POS_WIDTH-1:0]     r_f1_pos, r_f2_pos;
    logic signed [SW-1:0]       v [9];
    logic signed [SW-1:0]       e [9];
    logic [9*AW-1:0]            n_axes;
    logic [9*AW-1:0]            r_axes;

    assign en      = !i_full;
    assign o_ready = en;
    assign o_push  = r_f2.valid && en;
    assign o_data  = {r_f2_pos, r_f2_half, r_axes, r_f2.op};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1 <= '0;
            r_f2 <= '0;
        end else if (en) begin
            r_f1 <= '{valid: i_valid, op: i_op};
            r_f2 <= r_f1;
        end
    end

    // Products in the order yy, zz, xx, xy, wz, xz, wy, yz, wx.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0]    <= i_qy * i_qy;
            r_p[1]    <= i_qz * i_qz;
            r_p[2]    <= i_qx * i_qx;
            r_p[3]    <= i_qx * i_qy;
            r_p[4]    <= i_qw * i_qz;
            r_p[5]    <= i_qx * i_qz;
            r_p[6]    <= i_qw * i_qy;
            r_p[7]    <= i_qy * i_qz;
            r_p[8]    <= i_qw * i_qx;
            r_f1_half <= i_half;
            r_f1_pos  <= i_pos;
            r_axes    <= n_axes;
            r_f2_half <= r_f1_half;
            r_f2_pos  <= r_f1_pos;
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            e[k] = SW'(r_p[k]);
        end
        v[0] = ONE - ((e[0] + e[1]) <<< 1);
        v[1] = (e[3] + e[4]) <<< 1;
        v[2] = (e[5] - e[6]) <<< 1;
        v[3] = (e[3] - e[4]) <<< 1;
        v[4] = ONE - ((e[2] + e[1]) <<< 1);
        v[5] = (e[7] + e[8]) <<< 1;
        v[6] = (e[5] + e[6]) <<< 1;
        v[7] = (e[7] - e[8]) <<< 1;
        v[8] = ONE - ((e[2] + e[0]) <<< 1);
        for (int k = 0; k < 9; k++) begin
            n_axes[k*AW +: AW] = axis_fix(v[k]);
        end
    end

endmodule

@@ rtl/obb_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_fifo
// Short queue between the axis front and the test back.
// ----------------------------------------------------------------------------
module obb_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_nempty,
    output logic [W-1:0] o_data
);

    localparam int D  = obb_pkg::FIFO_DEPTH;
    localparam int AB = $clog2(D);
    localparam int CB = $clog2(D + 1);

    logic [W-1:0]  r_mem [D];
    logic [AB-1:0] r_wp, r_rp;
    logic [CB-1:0] r_cnt;

    assign o_full   = (r_cnt == CB'(D));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AB'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + AB'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CB'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/obb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_back
// Holds the reference box and runs the 15 separating-axis tests.
// ----------------------------------------------------------------------------
module obb_back #(
    parameter int POS_WIDTH     = 24,
    parameter int EXTENT_WIDTH  = 20,
    parameter int ROT_FRAC_BITS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_nempty,
    output logic o_q_pop,
    input  logic [1+9*(ROT_FRAC_BITS+2)+3*EXTENT_WIDTH+3*POS_WIDTH-1:0] i_q_data,
    output logic o_valid,
    input  logic i_ready,
    output logic o_overlap
);

    localparam int F   = ROT_FRAC_BITS;
    localparam int AW  = F + 2;
    localparam int EW  = EXTENT_WIDTH;
    localparam int PW  = POS_WIDTH;
    localparam int PAW = 2 * AW;
    localparam int TQW = PW + 1 + AW;
    localparam int SRW = PAW + 2;
    localparam int RW  = SRW - F;
    localparam int STW = TQW + 2;
    localparam int TW  = STW - F;
    localparam int CW  = ((TW > EW + 1) ? TW : EW + 1) + RW + 3;
    localparam logic signed [SRW-1:0] RHALF = SRW'(1) <<< (F - 1);
    localparam logic signed [STW-1:0] THALF = STW'(1) <<< (F - 1);

    logic en, pop;
    logic q_op;
    logic signed [AW-1:0] q_ax [3][3];
    logic [EW-1:0]        q_eb [3];
    logic signed [PW-1:0] q_pb [3];

    logic signed [AW-1:0] r_ref_ax [3][3];
    logic [EW-1:0]        r_ref_half [3];
    logic signed [PW-1:0] r_ref_pos [3];

    obb_pkg::t_stage_ctl  r_b1, r_b2, r_b3;
    logic signed [PAW-1:0] r_pr [3][3][3];
    logic signed [TQW-1:0] r_tq [3][3];
    logic [EW-1:0]         r_b1_eb [3], r_b2_eb [3];
    logic [EW-1:0]         r_b1_rh [3], r_b2_rh [3];

    logic signed [RW-1:0]  n_r [3][3];
    logic [RW-1:0]         n_ar [3][3];
    logic signed [TW-1:0]  n_tp [3];
    logic signed [RW-1:0]  r_r [3][3];
    logic [RW-1:0]         r_ar [3][3];
    logic signed [TW-1:0]  r_tp [3], r_b3_tp [3];

    logic [EW+RW-1:0]         r_me [3][3][3];
    logic [EW+RW-1:0]         r_mh [3][3][3];
    logic signed [TW+RW-1:0]  r_mt [3][3][3];
    logic [EW-1:0]            r_b3_eb [3], r_b3_rh [3];

    logic                  r_ov, r_ovl;
    logic [14:0]           sep;

    assign en      = !r_ov || i_ready;
    assign pop     = en && i_q_nempty;
    assign o_q_pop = pop;
    assign o_valid = r_ov;
    assign o_overlap = r_ovl;

    always_comb begin
        q_op = i_q_data[0];
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                q_ax[a][k] = i_q_data[1 + (3*a+k)*AW +: AW];
            end
            q_eb[a] = i_q_data[1 + 9*AW + a*EW +: EW];
            q_pb[a] = i_q_data[1 + 9*AW + 3*EW + a*PW +: PW];
        end
    end

    // A loaded reference applies to every item that leaves the queue after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r_ref_ax[a][k] <= '0;
                end
                r_ref_half[a] <= '0;
                r_ref_pos[a]  <= '0;
            end
        end else if (pop && q_op == obb_pkg::OP_LOAD) begin
            r_ref_ax   <= q_ax;
            r_ref_half <= q_eb;
            r_ref_pos  <= q_pb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1 <= '0;
            r_b2 <= '0;
            r_b3 <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_b1 <= '{valid: i_q_nempty, op: q_op};
            r_b2 <= r_b1;
            r_b3 <= r_b2;
            r_ov <= r_b3.valid && (r_b3.op == obb_pkg::OP_TEST);
        end
    end

    // Stage 1: axis dot products and translation projections.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_pr[i][j][k] <= PAW'(r_ref_ax[i][k]) * PAW'(q_ax[j][k]);
                    end
                end
                for (int k = 0; k < 3; k++) begin
                    r_tq[i][k] <= (TQW'(q_pb[k]) - TQW'(r_ref_pos[k]))
                                * TQW'(r_ref_ax[i][k]);
                end
            end
            r_b1_eb <= q_eb;
            r_b1_rh <= r_ref_half;
        end
    end

    // Stage 2: rounding of the relative rotation and the projected translation.
    always_comb begin
        logic signed [SRW-1:0] s;
        logic signed [STW-1:0] st;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s = SRW'(r_pr[i][j][0]) + SRW'(r_pr[i][j][1]) + SRW'(r_pr[i][j][2]);
                s = (s + RHALF) >>> F;
                n_r[i][j]  = s[RW-1:0];
                n_ar[i][j] = (n_r[i][j] < 0 ? -n_r[i][j] : n_r[i][j]) + RW'(1);
            end
            st = STW'(r_tq[i][0]) + STW'(r_tq[i][1]) + STW'(r_tq[i][2]);
            st = (st + THALF) >>> F;
            n_tp[i] = st[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r     <= n_r;
            r_ar    <= n_ar;
            r_tp    <= n_tp;
            r_b2_eb <= r_b1_eb;
            r_b2_rh <= r_b1_rh;
        end
    end

    // Stage 3: every extent and translation product the tests need.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_me[a][b][j] <= (EW+RW)'(r_b2_eb[a]) * (EW+RW)'(r_ar[b][j]);
                        r_mh[a][b][j] <= (EW+RW)'(r_b2_rh[a]) * (EW+RW)'(r_ar[b][j]);
                        r_mt[a][b][j] <= (TW+RW)'(r_tp[a]) * (TW+RW)'(r_r[b][j]);
                    end
                end
            end
            r_b3_tp <= r_tp;
            r_b3_eb <= r_b2_eb;
            r_b3_rh <= r_b2_rh;
        end
    end

    // Stage 4: the 15 axis tests; an axis separates only on strict excess.
    always_comb begin
        logic signed [CW-1:0] lhs, lim;
        for (int i = 0; i < 3; i++) begin
            lhs = CW'(r_b3_tp[i]) <<< F;
            lhs = lhs < 0 ? -lhs : lhs;
            lim = (CW'(r_b3_rh[i]) <<< F) + CW'(r_me[0][i][0]) + CW'(r_me[1][i][1])
                + CW'(r_me[2][i][2]);
            sep[i] = lhs > lim;
        end
        for (int i = 0; i < 3; i++) begin
            lhs = CW'(r_mt[0][0][i]) + CW'(r_mt[1][1][i]) + CW'(r_mt[2][2][i]);
            lhs = lhs < 0 ? -lhs : lhs;
            lim = (CW'(r_b3_eb[i]) <<< F) + CW'(r_mh[0][0][i]) + CW'(r_mh[1][1][i])
                + CW'(r_mh[2][2][i]);
            sep[3+i] = lhs > lim;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                lhs = CW'(r_mt[(i+2)%3][(i+1)%3][j]) - CW'(r_mt[(i+1)%3][(i+2)%3][j]);
                lhs = lhs < 0 ? -lhs : lhs;
                lim = CW'(r_mh[(i+1)%3][(i+2)%3][j]) + CW'(r_mh[(i+2)%3][(i+1)%3][j])
                    + CW'(r_me[(j+1)%3][i][(j+2)%3]) + CW'(r_me[(j+2)%3][i][(j+1)%3]);
                sep[6+3*i+j] = lhs > lim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ovl <= ~|sep;
        end
    end

endmodule

@@ rtl/obb_overlap_sat_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_overlap_sat_test
// Oriented-box overlap test by the 15 separating axes.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields
// s (in)    in   tuser: op; tdata: quat_w,x,y,z, half_x,y,z, pos_x,y,z
// m (out)   out  tdata: overlap
//
// One item per cycle when neither the queue nor the output stalls; a test
// result passes through two axis stages, one queue slot, three test stages
// and the output register. Loads give no result. The front and back stall
// independently around a four-entry queue. Reset clears the reference box
// to zero, so a test before any load reports overlap.
// ----------------------------------------------------------------------------
module obb_overlap_sat_test #(
    parameter int POS_WIDTH     = 24,
    parameter int EXTENT_WIDTH  = 20,
    parameter int ROT_FRAC_BITS = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // quat_w, quat_x, quat_y, quat_z, half_x, half_y, half_z, pos_x, pos_y, pos_z
    input  logic [199:0] i_s_tdata,
    // op
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // overlap
    output logic [7:0]   o_m_tdata
);

    localparam int QW  = obb_pkg::QUAT_W;
    localparam int HFW = obb_pkg::HALF_FIELD_W;
    localparam int PFW = obb_pkg::POS_FIELD_W;
    localparam int HB  = 4 * QW;
    localparam int PB  = HB + 3 * HFW;
    localparam int HXW = (EXTENT_WIDTH > HFW) ? EXTENT_WIDTH : HFW;
    localparam int PXW = (POS_WIDTH > PFW) ? POS_WIDTH : PFW;
    localparam int DW  = 1 + 9 * (ROT_FRAC_BITS + 2) + 3 * EXTENT_WIDTH + 3 * POS_WIDTH;

    logic [3*EXTENT_WIDTH-1:0] half;
    logic [3*POS_WIDTH-1:0]    pos;
    logic [HXW-1:0]            hx [3];
    logic [PXW-1:0]            px [3];
    logic                      full, push, nempty, pop, overlap;
    logic [DW-1:0]             f_data, q_data;

    // Positions are signed, so a wider internal position is sign-extended.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hx[k] = HXW'(i_s_tdata[HB + k*HFW +: HFW]);
            px[k] = PXW'($signed(i_s_tdata[PB + k*PFW +: PFW]));
            half[k*EXTENT_WIDTH +: EXTENT_WIDTH] = hx[k][EXTENT_WIDTH-1:0];
            pos[k*POS_WIDTH +: POS_WIDTH]        = px[k][POS_WIDTH-1:0];
        end
    end

    obb_front #(
        .POS_WIDTH     (POS_WIDTH),
        .EXTENT_WIDTH  (EXTENT_WIDTH),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser),
        .i_qw    (i_s_tdata[0*QW +: QW]),
        .i_qx    (i_s_tdata[1*QW +: QW]),
        .i_qy    (i_s_tdata[2*QW +: QW]),
        .i_qz    (i_s_tdata[3*QW +: QW]),
        .i_half  (half),
        .i_pos   (pos),
        .i_full  (full),
        .o_push  (push),
        .o_data  (f_data)
    );

    obb_fifo #(
        .W (DW)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (f_data),
        .o_full   (full),
        .i_pop    (pop),
        .o_nempty (nempty),
        .o_data   (q_data)
    );

    obb_back #(
        .POS_WIDTH     (POS_WIDTH),
        .EXTENT_WIDTH  (EXTENT_WIDTH),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_nempty (nempty),
        .o_q_pop    (pop),
        .i_q_data   (q_data),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_overlap  (overlap)
    );

    assign o_m_tdata = {7'd0, overlap};

endmodule

@@ rtl/obb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_port_props
// Port-level checks of the overlap test, bound to the top level.
// ----------------------------------------------------------------------------
module obb_port_props (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [7:0]   o_m_tdata
);

    logic [4:0] r_pend;
    logic       in_test, out_xfer;

    assign in_test  = i_s_tvalid && o_s_tready && (i_s_tuser == obb_pkg::OP_TEST);
    assign out_xfer = o_m_tvalid && i_m_tready;

    // Tests taken in but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_test && !out_xfer) begin
            r_pend <= r_pend + 5'd1;
        end else if (!in_test && out_xfer) begin
            r_pend <= r_pend - 5'd1;
        end
    end

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_pend != 5'd0)
        else $error("result without a pending test");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 5'd10)
        else $error("more tests in flight than the pipeline holds");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

endmodule

bind obb_overlap_sat_test obb_port_props u_obb_port_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ tb/obb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_checker
// Watches both streams of the oriented-box overlap test, predicts each overlap
// flag from the accepted input transfers and compares it with the output.
// ----------------------------------------------------------------------------
module obb_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [199:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [7:0]   i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int FRAC = 14;

    typedef logic signed [63:0] t_s64;

    t_s64 box_axes[9];
    t_s64 box_half[3];
    t_s64 box_pos[3];
    bit   overlap_q[$];

    function automatic t_s64 round_frac(t_s64 v);
        return (v + (t_s64'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic t_s64 axis_round(t_s64 v);
        t_s64 r;
        r = round_frac(v);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic t_s64 mag(t_s64 v);
        return (v < 0) ? -v : v;
    endfunction

    // Rotation columns of the quaternion, with 1 in place of its squared norm.
    task automatic quat_to_axes(input logic [199:0] d, output t_s64 ax[9]);
        t_s64 w, x, y, z, one;
        w = t_s64'($signed(d[15:0]));
        x = t_s64'($signed(d[31:16]));
        y = t_s64'($signed(d[47:32]));
        z = t_s64'($signed(d[63:48]));
        one = t_s64'(1) <<< (2 * FRAC);
        ax[0] = axis_round(one - 2 * (y * y + z * z));
        ax[1] = axis_round(2 * (x * y + w * z));
        ax[2] = axis_round(2 * (x * z - w * y));
        ax[3] = axis_round(2 * (x * y - w * z));
        ax[4] = axis_round(one - 2 * (x * x + z * z));
        ax[5] = axis_round(2 * (y * z + w * x));
        ax[6] = axis_round(2 * (x * z + w * y));
        ax[7] = axis_round(2 * (y * z - w * x));
        ax[8] = axis_round(one - 2 * (x * x + y * y));
    endtask

    task automatic accept_box(input logic op, input logic [199:0] d);
        t_s64 bx[9];
        t_s64 eb[3], pb[3], tv[3], tp[3], r[3][3], ar[3][3];
        t_s64 ra, rb, lhs, s;
        bit   sep;
        int   i1, i2, j1, j2;
        quat_to_axes(d, bx);
        for (int k = 0; k < 3; k++) begin
            eb[k] = t_s64'(d[64 + 20 * k +: 20]);
            pb[k] = t_s64'($signed(d[124 + 24 * k +: 24]));
        end
        if (op == obb_pkg::OP_LOAD) begin
            box_axes = bx;
            box_half = eb;
            box_pos  = pb;
            return;
        end
        sep = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s = 0;
                for (int k = 0; k < 3; k++) s += box_axes[3 * i + k] * bx[3 * j + k];
                r[i][j]  = round_frac(s);
                ar[i][j] = mag(r[i][j]) + 1;
            end
        end
        for (int k = 0; k < 3; k++) tv[k] = pb[k] - box_pos[k];
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s += tv[k] * box_axes[3 * i + k];
            tp[i] = round_frac(s);
        end
        for (int i = 0; i < 3; i++) begin
            ra = box_half[i] <<< FRAC;
            rb = eb[0] * ar[i][0] + eb[1] * ar[i][1] + eb[2] * ar[i][2];
            if (mag(tp[i] <<< FRAC) > ra + rb) sep = 1;
        end
        for (int i = 0; i < 3; i++) begin
            rb  = eb[i] <<< FRAC;
            ra  = box_half[0] * ar[0][i] + box_half[1] * ar[1][i] + box_half[2] * ar[2][i];
            lhs = tp[0] * r[0][i] + tp[1] * r[1][i] + tp[2] * r[2][i];
            if (mag(lhs) > ra + rb) sep = 1;
        end
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1  = (j + 1) % 3;
                j2  = (j + 2) % 3;
                ra  = box_half[i1] * ar[i2][j] + box_half[i2] * ar[i1][j];
                rb  = eb[j1] * ar[i][j2] + eb[j2] * ar[i][j1];
                lhs = tp[i2] * r[i1][j] - tp[i1] * r[i2][j];
                if (mag(lhs) > ra + rb) sep = 1;
            end
        end
        overlap_q.push_back(!sep);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) box_axes[k] = 0;
            for (int k = 0; k < 3; k++) begin
                box_half[k] = 0;
                box_pos[k]  = 0;
            end
            overlap_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            // Output first: a result can never stem from this cycle's input.
            if (i_m_tvalid && i_m_tready) begin
                if (overlap_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    bit exp_ov;
                    exp_ov = overlap_q.pop_front();
                    if (i_m_tdata !== {7'd0, exp_ov}) begin
                        $display("%0t: overlap mismatch, expected %h, actual %h",
                                 $time, {7'd0, exp_ov}, i_m_tdata);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) accept_box(i_s_tuser, i_s_tdata);
            o_pending = overlap_q.size();
        end
    end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives reference loads and candidate tests into the overlap block, with
// directed boxes first and random ones after, under random stalls on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS = 1830;
    localparam int CYCLE_LIMIT  = 200000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    int           fail_count;
    int           pending;
    int           cycle_count;
    bit           calm_phase;
    bit           long_hold;

    obb_overlap_sat_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    obb_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none near the end.
    initial begin
        int n;
        m_tready = 0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                m_tready <= 0;
                repeat (60) @(posedge i_clk);
                long_hold = 0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                m_tready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [15:0] rand_quat_part();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'(($urandom_range(0, 32768)) - 16384);
            3: return 16'($urandom);
            default: return 16'(($urandom_range(0, 23170)) - 11585);
        endcase
    endfunction

    function automatic logic [199:0] rand_box(bit wide);
        logic [199:0] d;
        for (int k = 0; k < 4; k++) d[16 * k +: 16] = rand_quat_part();
        for (int k = 0; k < 3; k++)
            d[64 + 20 * k +: 20] = wide ? 20'($urandom) : 20'($urandom_range(0, 4000));
        for (int k = 0; k < 3; k++)
            d[124 + 24 * k +: 24] = wide ? 24'($urandom) : 24'($urandom_range(0, 12000) - 6000);
        d[199:196] = '0;
        return d;
    endfunction

    task automatic send_box(input logic op, input logic [199:0] d);
        int n;
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 9);
            s_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic logic [199:0] make_box(logic [15:0] w, logic [15:0] x,
                                              logic [15:0] y, logic [15:0] z,
                                              logic [19:0] h, logic [23:0] px);
        return {4'd0, 24'd0, 24'd0, px, h, h, h, z, y, x, w};
    endfunction

    initial begin
        int wait_n;
        i_rst_n     = 0;
        s_tvalid    = 0;
        s_tdata     = '0;
        s_tuser     = obb_pkg::OP_LOAD;
        cycle_count = 0;
        calm_phase  = 0;
        long_hold   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reference never loaded: any candidate overlaps.
        send_box(obb_pkg::OP_TEST, make_box(16'sd16384, 0, 0, 0, 20'd10, 24'd900000));
        send_box(obb_pkg::OP_TEST, {200{1'b1}} >> 4);
        // Identity reference, touching and just-separated candidates.
        send_box(obb_pkg::OP_LOAD, make_box(16'sd16384, 0, 0, 0, 20'd256, 24'd0));
        send_box(obb_pkg::OP_TEST, make_box(16'sd16384, 0, 0, 0, 20'd256, 24'd512));
        send_box(obb_pkg::OP_TEST, make_box(16'sd16384, 0, 0, 0, 20'd256, 24'd513));
        send_box(obb_pkg::OP_TEST, make_box(16'sd16384, 0, 0, 0, 20'd256, 24'd514));
        send_box(obb_pkg::OP_TEST, make_box(16'sd11585, 0, 0, 16'sd11585, 20'd256, 24'd700));
        // Extremes of the quaternion, extents and position.
        send_box(obb_pkg::OP_TEST, make_box(-16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                                            20'hFFFFF, 24'h800000));
        send_box(obb_pkg::OP_TEST, make_box(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                            20'd0, 24'h7FFFFF));
        send_box(obb_pkg::OP_LOAD, make_box(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                            20'hFFFFF, 24'h7FFFFF));
        send_box(obb_pkg::OP_TEST, make_box(0, 0, 16'sd16384, 0, 20'hFFFFF, 24'h800000));
        send_box(obb_pkg::OP_TEST, make_box(0, 0, 0, 0, 20'd0, 24'd0));
        send_box(obb_pkg::OP_LOAD, {4'd0, {196{1'b1}}});
        send_box(obb_pkg::OP_TEST, {4'd0, {196{1'b1}}});
        send_box(obb_pkg::OP_TEST, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300) long_hold = 1;
            if (i == RANDOM_ITEMS - 150) calm_phase = 1;
            send_box(($urandom_range(0, 4) == 0) ? obb_pkg::OP_LOAD : obb_pkg::OP_TEST,
                     rand_box($urandom_range(0, 9) == 0));
        end
        s_tvalid <= 0;

        wait_n = 0;
        while (pending != 0 && wait_n < 5000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/obb_pkg.sv
rtl/obb_front.sv
rtl/obb_fifo.sv
rtl/obb_back.sv
rtl/obb_overlap_sat_test.sv
rtl/obb_checker.sv
tb/obb_checker.sv
tb/tb.sv
